@@ rtl/assert_macros.svh @@
// assertion helpers for the tilt block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ata_pkg.sv @@
package ata_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ROTATION_STAGES = 16;

    localparam int ANGLE_W   = 15;
    localparam int IN_W      = 16;
    localparam int SQR_W     = 31;
    localparam int MAG_W     = 24;
    localparam int RAD_W     = 48;
    localparam int REM_W     = 27;
    localparam int CORDIC_W  = 28;
    localparam int ACC_W     = 32;
    localparam int SHIFT_W   = 5;
    localparam int SQ_STAGES = 24;
    localparam int TABLE_LEN = 24;
    localparam int CD_STAGES = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;
    localparam int LANES     = 3;

    localparam int RND_S       = 30 - ANGLE_FRAC_BITS;
    localparam int HALF_PI_Q30 = 32'h6487ED51;
    localparam int HP_INT      = (HALF_PI_Q30 + (1 << (RND_S - 1))) >> RND_S;
    localparam logic [ACC_W:0] HALF_LSB = (ACC_W+1)'(1 << (RND_S - 1));
    localparam logic [ACC_W:0] HALF_PI  = (ACC_W+1)'(HP_INT);

    // one square root lane: radicand shifts out two bits per cell
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [REM_W-1:0] rem;
        logic [MAG_W-1:0] root;
        logic [MAG_W-1:0] aux;
        logic             neg;
    } t_sq;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] px;
        logic signed [CORDIC_W-1:0] py;
        logic signed [ACC_W-1:0]    acc;
        logic                       mag_zero;
        logic                       den_zero;
        logic                       neg;
    } t_cd;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_side;

    // atan(2^-i), 2^-30 rad units, truncated
    function automatic logic signed [ACC_W-1:0] atan_q30(input logic [SHIFT_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // round half away from zero, clamp to [0, pi/2], apply special cases and sign
    function automatic logic [ANGLE_W-1:0] angle_out(input t_cd c);
        logic [ACC_W:0] mag;
        logic [ACC_W:0] r;
        logic [ACC_W:0] a;
        mag = c.acc[ACC_W-1] ? -{c.acc[ACC_W-1], c.acc} : {1'b0, c.acc};
        r   = (mag + HALF_LSB) >> RND_S;
        if (c.acc[ACC_W-1]) begin
            a = '0;
        end else begin
            a = (r > HALF_PI) ? HALF_PI : r;
        end
        if (c.mag_zero) begin
            a = '0;
        end else if (c.den_zero) begin
            a = HALF_PI;
        end
        if (c.neg) begin
            a = -a;
        end
        return a[ANGLE_W-1:0];
    endfunction

endpackage

@@ rtl/ata_sqrt_cell.sv @@
module ata_sqrt_cell (
    input  logic          i_clk,
    input  logic          i_en,
    input  ata_pkg::t_sq  i_sq,
    output ata_pkg::t_sq  o_sq
);
    import ata_pkg::*;

    logic [REM_W-1:0] w_rem;
    logic [REM_W-1:0] w_trial;
    t_sq              n_sq;
    t_sq              r_sq;

    assign w_rem   = {i_sq.rem[REM_W-3:0], i_sq.rad[RAD_W-1 -: 2]};
    assign w_trial = {1'b0, i_sq.root, 2'b01};

    always_comb begin
        n_sq      = i_sq;
        n_sq.rad  = {i_sq.rad[RAD_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_sq.rem  = w_rem - w_trial;
            n_sq.root = {i_sq.root[MAG_W-2:0], 1'b1};
        end else begin
            n_sq.rem  = w_rem;
            n_sq.root = {i_sq.root[MAG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;
endmodule

@@ rtl/ata_cordic_cell.sv @@
module ata_cordic_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [ata_pkg::SHIFT_W-1:0]  i_shift,
    input  ata_pkg::t_cd                 i_cd,
    output ata_pkg::t_cd                 o_cd
);
    import ata_pkg::*;

    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [ACC_W-1:0]    w_ang;
    t_cd                        n_cd;
    t_cd                        r_cd;

    assign w_dx  = i_cd.py >>> i_shift;
    assign w_dy  = i_cd.px >>> i_shift;
    assign w_ang = atan_q30(i_shift);

    // rotate toward the x axis
    always_comb begin
        n_cd = i_cd;
        if (!i_cd.py[CORDIC_W-1]) begin
            n_cd.px  = i_cd.px + w_dx;
            n_cd.py  = i_cd.py - w_dy;
            n_cd.acc = i_cd.acc + w_ang;
        end else begin
            n_cd.px  = i_cd.px - w_dx;
            n_cd.py  = i_cd.py + w_dy;
            n_cd.acc = i_cd.acc - w_ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cd <= n_cd;
        end
    end

    assign o_cd = r_cd;
endmodule

@@ rtl/accel_tilt_angles.sv @@
// channel | direction | handshake          | payload
// sample  | in        | i_valid / o_stall  | i_accel_x, i_accel_y, i_accel_z
// angles  | out       | o_valid / i_stall  | o_tilt_about_x_axis, o_tilt_about_y_axis,
//         |           |                    | o_angle_from_vertical, o_zero_vector
//
// One sample per cycle unless the output stalls; the pipe is the input register,
// the 24 square root cells, the rotation cells of each lane and the output register.
// Three lanes run side by side, one per angle.
// Synchronous active-low reset clears the valid line and the side-pipe valid and zero flags only.
// A stalled output beat freezes the whole pipe, and o_stall follows it.
`include "assert_macros.svh"

module accel_tilt_angles (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ata_pkg::IN_W-1:0]     i_accel_x,
    input  logic signed [ata_pkg::IN_W-1:0]     i_accel_y,
    input  logic signed [ata_pkg::IN_W-1:0]     i_accel_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ata_pkg::ANGLE_W-1:0]  o_tilt_about_x_axis,
    output logic signed [ata_pkg::ANGLE_W-1:0]  o_tilt_about_y_axis,
    output logic signed [ata_pkg::ANGLE_W-1:0]  o_angle_from_vertical,
    output logic                                o_zero_vector
);
    import ata_pkg::*;

    localparam int DEPTH = SQ_STAGES + CD_STAGES;

    logic                    w_en;
    logic signed [31:0]      w_px;
    logic signed [31:0]      w_py;
    logic signed [31:0]      w_pz;

    logic [SQR_W-1:0]        r_xx, r_yy, r_zz;
    logic [IN_W-1:0]         r_ax, r_ay, r_az;
    logic                    r_nx, r_ny, r_nz;
    t_side                   r_side [0:DEPTH];
    logic                    r_valid;
    logic [ANGLE_W-1:0]      r_ang [0:LANES-1];
    logic                    r_zero;

    t_sq                     w_sq [0:LANES-1][0:SQ_STAGES];
    t_cd                     w_cd [0:LANES-1][0:CD_STAGES];
    logic [31:0]             w_sum [0:LANES-1];

    assign w_en    = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    assign w_px = 32'(i_accel_x) * 32'(i_accel_x);
    assign w_py = 32'(i_accel_y) * 32'(i_accel_y);
    assign w_pz = 32'(i_accel_z) * 32'(i_accel_z);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_xx <= w_px[SQR_W-1:0];
            r_yy <= w_py[SQR_W-1:0];
            r_zz <= w_pz[SQR_W-1:0];
            r_ax <= i_accel_x[IN_W-1] ? IN_W'(-i_accel_x) : i_accel_x;
            r_ay <= i_accel_y[IN_W-1] ? IN_W'(-i_accel_y) : i_accel_y;
            r_az <= i_accel_z[IN_W-1] ? IN_W'(-i_accel_z) : i_accel_z;
            r_nx <= i_accel_x[IN_W-1];
            r_ny <= i_accel_y[IN_W-1];
            r_nz <= i_accel_z[IN_W-1];
        end
    end

    assign w_sum[0] = {1'b0, r_yy} + {1'b0, r_zz};
    assign w_sum[1] = {1'b0, r_xx} + {1'b0, r_zz};
    assign w_sum[2] = {1'b0, r_xx} + {1'b0, r_yy};

    always_comb begin
        w_sq[0][0] = '{rad: {w_sum[0], 16'b0}, rem: '0, root: '0,
                       aux: {r_ax, 8'b0}, neg: r_nx};
        w_sq[1][0] = '{rad: {w_sum[1], 16'b0}, rem: '0, root: '0,
                       aux: {r_ay, 8'b0}, neg: r_ny};
        w_sq[2][0] = '{rad: {w_sum[2], 16'b0}, rem: '0, root: '0,
                       aux: {r_az, 8'b0}, neg: r_nz};
    end

    genvar l, k;
    generate
        for (l = 0; l < LANES; l++) begin : g_lane
            for (k = 0; k < SQ_STAGES; k++) begin : g_sq
                ata_sqrt_cell u_sq (
                    .i_clk (i_clk),
                    .i_en  (w_en),
                    .i_sq  (w_sq[l][k]),
                    .o_sq  (w_sq[l][k+1])
                );
            end

            // the last lane puts the root on top and z below
            always_comb begin
                w_cd[l][0].neg = w_sq[l][SQ_STAGES].neg;
                w_cd[l][0].acc = '0;
                if (l == LANES - 1) begin
                    w_cd[l][0].px = CORDIC_W'(w_sq[l][SQ_STAGES].aux);
                    w_cd[l][0].py = CORDIC_W'(w_sq[l][SQ_STAGES].root);
                end else begin
                    w_cd[l][0].px = CORDIC_W'(w_sq[l][SQ_STAGES].root);
                    w_cd[l][0].py = CORDIC_W'(w_sq[l][SQ_STAGES].aux);
                end
                w_cd[l][0].mag_zero = (w_cd[l][0].py == '0);
                w_cd[l][0].den_zero = (w_cd[l][0].px == '0);
            end

            for (k = 0; k < CD_STAGES; k++) begin : g_cd
                ata_cordic_cell u_cd (
                    .i_clk   (i_clk),
                    .i_en    (w_en),
                    .i_shift (SHIFT_W'(k)),
                    .i_cd    (w_cd[l][k]),
                    .o_cd    (w_cd[l][k+1])
                );
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_ang[l] <= angle_out(w_cd[l][CD_STAGES]);
                end
            end
        end
    endgenerate

    // valid and zero flag ride alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DEPTH; i++) begin
                r_side[i] <= '0;
            end
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_side[0].valid <= i_valid;
            r_side[0].zero  <= (i_accel_x == '0) && (i_accel_y == '0) && (i_accel_z == '0);
            for (int i = 1; i <= DEPTH; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_valid <= r_side[DEPTH].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zero <= r_side[DEPTH].zero;
        end
    end

    assign o_valid               = r_valid;
    assign o_tilt_about_x_axis   = r_ang[0];
    assign o_tilt_about_y_axis   = r_ang[1];
    assign o_angle_from_vertical = r_ang[2];
    assign o_zero_vector         = r_zero;

    `ASSERT_RUN(a_zero_angles, i_clk, i_rst_n,
        (o_valid && o_zero_vector) |-> (o_tilt_about_x_axis == '0 &&
            o_tilt_about_y_axis == '0 && o_angle_from_vertical == '0),
        "zero vector beat with nonzero angle")
    `ASSERT_ALWAYS(a_reset_idle, i_clk,
        !$past(i_rst_n) |-> !o_valid,
        "output valid right after reset")
    `ASSERT_RUN(a_stall_freeze, i_clk, i_rst_n,
        $past(o_valid && i_stall) |-> $stable(r_side[DEPTH]),
        "pipe moved under output stall")

endmodule

@@ sim/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ata_pkg::*;

    localparam int LATENCY    = 2 + 24 + ROTATION_STAGES;
    localparam int WDOG_LIMIT = 4000;
    localparam int RND_SHIFT  = 30 - ANGLE_FRAC_BITS;
    localparam longint Q30_HALF_PI = 64'h6487ED51;

    typedef struct {
        logic [ANGLE_W-1:0] tilt_x;
        logic [ANGLE_W-1:0] tilt_y;
        logic [ANGLE_W-1:0] vert;
        logic               zero;
    } t_tilt;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic signed [IN_W-1:0]   i_accel_x;
    logic signed [IN_W-1:0]   i_accel_y;
    logic signed [IN_W-1:0]   i_accel_z;
    logic                     o_valid;
    logic                     i_stall;
    logic signed [ANGLE_W-1:0] o_tilt_about_x_axis;
    logic signed [ANGLE_W-1:0] o_tilt_about_y_axis;
    logic signed [ANGLE_W-1:0] o_angle_from_vertical;
    logic                     o_zero_vector;

    t_tilt expected_angles[$];
    int    n_errors   = 0;
    int    n_samples  = 0;
    int    n_results  = 0;
    int    n_zero_vec = 0;
    int    idle_cnt   = 0;
    bit    gaps_on    = 1'b0;

    accel_tilt_angles dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // ---- predictor ----
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r  = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_q30(input longint v);
        longint half;
        half = longint'(1) << (RND_SHIFT - 1);
        if (v < 0) return -((-v + half) >>> RND_SHIFT);
        return (v + half) >>> RND_SHIFT;
    endfunction

    function automatic logic [ANGLE_W-1:0] atan2_angle(input bit neg,
            input longint mag, input longint den);
        longint hp;
        longint a;
        longint px;
        longint py;
        longint acc;
        longint dx;
        longint dy;
        hp = round_q30(Q30_HALF_PI);
        if (mag == 0) begin
            a = 0;
        end else if (den == 0) begin
            a = hp;
        end else begin
            px  = den;
            py  = mag;
            acc = 0;
            for (int i = 0; i < CD_STAGES; i++) begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0) begin
                    px  += dx;
                    py  -= dy;
                    acc += longint'(atan_q30(i[SHIFT_W-1:0]));
                end else begin
                    px  -= dx;
                    py  += dy;
                    acc -= longint'(atan_q30(i[SHIFT_W-1:0]));
                end
            end
            a = round_q30(acc);
            if (a < 0) a = 0;
            if (a > hp) a = hp;
        end
        if (neg) a = -a;
        return a[ANGLE_W-1:0];
    endfunction

    function automatic t_tilt predict_tilt(input logic signed [IN_W-1:0] x,
            input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] z);
        t_tilt  t;
        longint sx;
        longint sy;
        longint sz;
        sx = x;
        sy = y;
        sz = z;
        t.tilt_x = atan2_angle(sx < 0, (sx < 0 ? -sx : sx) * 256,
                               floor_sqrt((sy * sy + sz * sz) << 16));
        t.tilt_y = atan2_angle(sy < 0, (sy < 0 ? -sy : sy) * 256,
                               floor_sqrt((sx * sx + sz * sz) << 16));
        t.vert   = atan2_angle(sz < 0, floor_sqrt((sx * sx + sy * sy) << 16),
                               (sz < 0 ? -sz : sz) * 256);
        t.zero   = (x == 0 && y == 0 && z == 0);
        return t;
    endfunction

    // ---- sample side ----
    task automatic send_sample(input logic signed [IN_W-1:0] x,
            input logic signed [IN_W-1:0] y, input logic signed [IN_W-1:0] z);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_accel_x <= x;
        i_accel_y <= y;
        i_accel_z <= z;
        do @(posedge i_clk); while (o_stall);
        expected_angles.push_back(predict_tilt(x, y, z));
        n_samples++;
    endtask

    task automatic idle_gap();
        int n;
        if (!gaps_on || $urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 19);
        @(negedge i_clk);
        i_valid   <= 1'b0;
        i_accel_x <= IN_W'($urandom);
        i_accel_y <= IN_W'($urandom);
        i_accel_z <= IN_W'($urandom);
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_random_sample();
        logic signed [IN_W-1:0] v[3];
        int kind;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            case (kind)
                0, 1, 2, 3: v[k] = IN_W'($urandom);
                4, 5:       v[k] = IN_W'($signed(IN_W'($urandom_range(0, 32))) - 16);
                6:          v[k] = ($urandom_range(0, 2) == 0) ? '0 : IN_W'($urandom);
                7:          v[k] = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
                8:          v[k] = IN_W'($signed(IN_W'($urandom_range(0, 33000))) - 16500);
                default:    v[k] = $signed(IN_W'($urandom_range(0, 8))) * 16'sd4096;
            endcase
        end
        send_sample(v[0], v[1], v[2]);
        idle_gap();
    endtask

    // ---- angles side ----
    initial begin
        int n;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 19);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tilt e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (expected_angles.size() == 0) begin
                $error("angles beat with nothing pending");
                n_errors++;
            end else begin
                e = expected_angles.pop_front();
                if (o_zero_vector) n_zero_vec++;
                if (o_tilt_about_x_axis !== e.tilt_x) begin
                    $error("tilt_about_x_axis exp %0d got %0d",
                           $signed(e.tilt_x), o_tilt_about_x_axis);
                    n_errors++;
                end
                if (o_tilt_about_y_axis !== e.tilt_y) begin
                    $error("tilt_about_y_axis exp %0d got %0d",
                           $signed(e.tilt_y), o_tilt_about_y_axis);
                    n_errors++;
                end
                if (o_angle_from_vertical !== e.vert) begin
                    $error("angle_from_vertical exp %0d got %0d",
                           $signed(e.vert), o_angle_from_vertical);
                    n_errors++;
                end
                if (o_zero_vector !== e.zero) begin
                    $error("zero_vector exp %0b got %0b", e.zero, o_zero_vector);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt >= WDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ---- tests ----
    task automatic test_directed();
        send_sample(0, 0, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 0, 0);
        send_sample(16'sh8000, 0, 0);
        send_sample(0, 16'sh7FFF, 0);
        send_sample(0, 16'sh8000, 0);
        send_sample(0, 0, 16'sh7FFF);
        send_sample(0, 0, 16'sh8000);
        send_sample(16384, 0, 16384);
        send_sample(0, -16384, -16384);
        send_sample(1, 0, 0);
        send_sample(-1, -1, -1);
        send_sample(1, 1, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000, 1);
        send_sample(100, -200, -16384);
        send_sample(-5000, 3000, 0);
        send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
        send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
        send_sample(0, 0, 0);
    endtask

    task automatic test_random_bursts(input int count);
        gaps_on = 1'b1;
        repeat (count) send_random_sample();
    endtask

    task automatic test_drain_pause();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (expected_angles.size() == 0);
        repeat (4) send_random_sample();
    endtask

    task automatic test_full_rate(input int count);
        gaps_on = 1'b0;
        repeat (count) send_random_sample();
    endtask

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_accel_x = '0;
        i_accel_y = '0;
        i_accel_z = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_bursts(240);
        test_drain_pause();
        test_random_bursts(200);
        test_full_rate(60);

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (expected_angles.size() == 0);
        repeat (LATENCY + 8) @(negedge i_clk);

        $display("covered %0d samples and %0d angle beats, %0d all-zero vectors,",
                 n_samples, n_results, n_zero_vec);
        $display("axis extremes, zero denominators, negative z and random stalls");
        if (n_errors == 0 && expected_angles.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
